// ===== rtl/sfp_pkg.sv =====
package sfp_pkg;

    // Default largest frame size in bytes (start, key, count, payload, checksum).
    localparam int MAX_FRAME_BYTES_DEF = 64;

    // Reset values of the configuration registers.
    localparam logic [7:0] START_BYTE_RST     = 8'h2e;
    localparam logic [7:0] URGENT_KEY_A_RST   = 8'h81;
    localparam logic [7:0] URGENT_KEY_B_RST   = 8'h82;
    localparam logic [3:0] URGENT_REPEATS_RST = 4'd5;
    localparam logic [5:0] MAX_PAYLOAD_RST    = 6'd60;

    // Largest number of copies one frame may produce.
    localparam logic [3:0] MAX_COPIES = 4'd8;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_START_BYTE     = 3'd0,
        CFG_URGENT_KEY_A   = 3'd1,
        CFG_URGENT_KEY_B   = 3'd2,
        CFG_URGENT_REPEATS = 3'd3,
        CFG_MAX_PAYLOAD    = 3'd4
    } cfg_index_t;

    // Parser phases.
    typedef enum logic [2:0] {
        PH_HUNT    = 3'd0,
        PH_KEY     = 3'd1,
        PH_COUNT   = 3'd2,
        PH_PAYLOAD = 3'd3,
        PH_SUM     = 3'd4
    } phase_t;

    // Configuration registers as seen by the parser.
    typedef struct packed {
        logic [7:0] start_byte;
        logic [7:0] urgent_key_a;
        logic [7:0] urgent_key_b;
        logic [3:0] urgent_repeats;
        logic [5:0] max_payload;
    } cfg_t;

    // A finished frame handed from the parser to the emitter.
    typedef struct packed {
        logic       valid;
        logic [7:0] key;
        logic [7:0] value;
        logic       err;
        logic [3:0] copies;
    } frame_event_t;

endpackage

// ===== rtl/sum_checked_frame_parser.sv =====
// A frame's first result is offered in the cycle after its checksum byte is accepted.
// Throughput: one received byte per cycle; a checksum byte waits only while the copies
// of the previous frame drain, one per cycle while out_ready is high, up to eight per urgent frame.
// The copy counter in the emitter holds the number of copies still to drain.
// Reset (rst_n low, asynchronous) returns to hunting, clears the frame state,
// drops any pending results and restores the register defaults.
module sum_checked_frame_parser #(
    parameter int MAX_FRAME_BYTES = sfp_pkg::MAX_FRAME_BYTES_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [2:0] cfg_index,
    input  logic [7:0] cfg_data,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] msg_key,
    output logic [7:0] msg_value,
    output logic       sum_error,
    output logic       last_copy
);

    sfp_pkg::cfg_t         cfg_reg;
    sfp_pkg::frame_event_t evt;
    logic                  at_sum;
    logic                  can_load;
    logic                  take;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_byte     <= sfp_pkg::START_BYTE_RST;
            cfg_reg.urgent_key_a   <= sfp_pkg::URGENT_KEY_A_RST;
            cfg_reg.urgent_key_b   <= sfp_pkg::URGENT_KEY_B_RST;
            cfg_reg.urgent_repeats <= sfp_pkg::URGENT_REPEATS_RST;
            cfg_reg.max_payload    <= sfp_pkg::MAX_PAYLOAD_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                sfp_pkg::CFG_START_BYTE:     cfg_reg.start_byte     <= cfg_data;
                sfp_pkg::CFG_URGENT_KEY_A:   cfg_reg.urgent_key_a   <= cfg_data;
                sfp_pkg::CFG_URGENT_KEY_B:   cfg_reg.urgent_key_b   <= cfg_data;
                sfp_pkg::CFG_URGENT_REPEATS: cfg_reg.urgent_repeats <= cfg_data[3:0];
                sfp_pkg::CFG_MAX_PAYLOAD:    cfg_reg.max_payload    <= cfg_data[5:0];
                default: ;
            endcase
        end
    end

    // Only the checksum byte needs room in the emitter.
    assign in_ready = !at_sum || can_load;
    assign take     = in_valid && in_ready;

    sfp_parser #(
        .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
    ) u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .take    (take),
        .rx_byte (rx_byte),
        .at_sum  (at_sum),
        .evt     (evt)
    );

    sfp_emitter u_emitter (
        .clk       (clk),
        .rst_n     (rst_n),
        .evt       (evt),
        .can_load  (can_load),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .msg_key   (msg_key),
        .msg_value (msg_value),
        .sum_error (sum_error),
        .last_copy (last_copy)
    );

    // An error request is always a single, final copy with cleared fields.
    a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && sum_error |-> last_copy && (msg_key == 8'd0) && (msg_value == 8'd0))
        else $error("checksum error request is not a single cleared copy");

    // Taking a non-final copy leaves another copy of the same good message.
    a_more_copies: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last_copy |=>
            out_valid && !sum_error && $stable(msg_key) && $stable(msg_value))
        else $error("repeated message lost or changed between copies");

    // A checksum byte is only taken when the emitter has room for its request.
    a_load_room: assert property (@(posedge clk) disable iff (!rst_n)
        evt.valid |-> can_load)
        else $error("frame result loaded over a pending request");

    // An accepted checksum byte always yields a request in the next cycle.
    a_sum_result: assert property (@(posedge clk) disable iff (!rst_n)
        take && at_sum |=> out_valid)
        else $error("checksum byte produced no request");

endmodule

// ===== rtl/sfp_parser.sv =====
module sfp_parser #(
    parameter int MAX_FRAME_BYTES = sfp_pkg::MAX_FRAME_BYTES_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  sfp_pkg::cfg_t        cfg,
    input  logic                 take,
    input  logic [7:0]           rx_byte,
    output logic                 at_sum,
    output sfp_pkg::frame_event_t evt
);

    // Hard cap on the payload count set by the frame size.
    localparam logic [8:0] CountLimit = 9'(MAX_FRAME_BYTES - 4);

    sfp_pkg::phase_t phase_reg, phase_next;
    logic [7:0] key_reg, key_next;
    logic [5:0] left_reg, left_next;
    logic [7:0] sum_reg, sum_next;
    logic [7:0] value_reg, value_next;
    logic       taken_reg, taken_next;

    logic [7:0] frame_value;
    logic       urgent;
    logic [3:0] reps;

    assign at_sum = (phase_reg == sfp_pkg::PH_SUM);

    // Copy count for urgent keys, clamped to one through eight.
    assign urgent = (key_reg == cfg.urgent_key_a) || (key_reg == cfg.urgent_key_b);
    always_comb
    begin
        if (cfg.urgent_repeats == 4'd0)
            reps = 4'd1;
        else if (cfg.urgent_repeats > sfp_pkg::MAX_COPIES)
            reps = sfp_pkg::MAX_COPIES;
        else
            reps = cfg.urgent_repeats;
    end

    // The byte at frame position three is the checksum when no payload came.
    assign frame_value = taken_reg ? value_reg : rx_byte;

    // Frame event, produced on the checksum byte.
    always_comb
    begin
        evt.valid  = take && at_sum;
        evt.err    = (rx_byte != sum_reg);
        evt.key    = evt.err ? 8'd0 : key_reg;
        evt.value  = evt.err ? 8'd0 : frame_value;
        evt.copies = (evt.err || !urgent) ? 4'd1 : reps;
    end

    // Phase sequencing and frame bookkeeping.
    always_comb
    begin
        phase_next = phase_reg;
        key_next   = key_reg;
        left_next  = left_reg;
        sum_next   = sum_reg;
        value_next = value_reg;
        taken_next = taken_reg;
        if (take)
        begin
            unique case (phase_reg)
                sfp_pkg::PH_KEY:
                begin
                    key_next   = rx_byte;
                    sum_next   = rx_byte;
                    taken_next = 1'b0;
                    value_next = 8'd0;
                    phase_next = sfp_pkg::PH_COUNT;
                end
                sfp_pkg::PH_COUNT:
                begin
                    if ((rx_byte > {2'b00, cfg.max_payload}) || ({1'b0, rx_byte} > CountLimit))
                        phase_next = sfp_pkg::PH_HUNT;
                    else
                    begin
                        sum_next   = sum_reg + rx_byte;
                        left_next  = rx_byte[5:0];
                        phase_next = (rx_byte[5:0] == 6'd0) ? sfp_pkg::PH_SUM
                                                             : sfp_pkg::PH_PAYLOAD;
                    end
                end
                sfp_pkg::PH_PAYLOAD:
                begin
                    sum_next = sum_reg + rx_byte;
                    if (!taken_reg)
                    begin
                        value_next = rx_byte;
                        taken_next = 1'b1;
                    end
                    left_next = left_reg - 6'd1;
                    if (left_reg == 6'd1)
                        phase_next = sfp_pkg::PH_SUM;
                end
                sfp_pkg::PH_SUM:
                begin
                    phase_next = sfp_pkg::PH_HUNT;
                    if (!taken_reg)
                    begin
                        value_next = rx_byte;
                        taken_next = 1'b1;
                    end
                end
                default:
                begin
                    phase_next = (rx_byte == cfg.start_byte) ? sfp_pkg::PH_KEY
                                                             : sfp_pkg::PH_HUNT;
                end
            endcase
        end
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= sfp_pkg::PH_HUNT;
            key_reg   <= 8'd0;
            left_reg  <= 6'd0;
            sum_reg   <= 8'd0;
            value_reg <= 8'd0;
            taken_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            key_reg   <= key_next;
            left_reg  <= left_next;
            sum_reg   <= sum_next;
            value_reg <= value_next;
            taken_reg <= taken_next;
        end
    end

endmodule

// ===== rtl/sfp_emitter.sv =====
module sfp_emitter (
    input  logic                  clk,
    input  logic                  rst_n,
    input  sfp_pkg::frame_event_t evt,
    output logic                  can_load,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [7:0]            msg_key,
    output logic [7:0]            msg_value,
    output logic                  sum_error,
    output logic                  last_copy
);

    logic [3:0] cnt_reg, cnt_next;
    logic [7:0] key_reg, key_next;
    logic [7:0] value_reg, value_next;
    logic       err_reg, err_next;
    logic       pop;

    assign out_valid = (cnt_reg != 4'd0);
    assign last_copy = (cnt_reg == 4'd1);
    assign msg_key   = key_reg;
    assign msg_value = value_reg;
    assign sum_error = err_reg;
    assign pop       = out_valid && out_ready;

    // A new frame may load once the final copy is leaving or nothing is held.
    assign can_load = !out_valid || (pop && last_copy);

    // Copy counter and held message.
    always_comb
    begin
        cnt_next   = cnt_reg;
        key_next   = key_reg;
        value_next = value_reg;
        err_next   = err_reg;
        if (evt.valid)
        begin
            cnt_next   = evt.copies;
            key_next   = evt.key;
            value_next = evt.value;
            err_next   = evt.err;
        end
        else if (pop)
            cnt_next = cnt_reg - 4'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 4'd0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        value_reg <= value_next;
        err_reg   <= err_next;
    end

endmodule
